FILE: design/bdcm_pkg.sv
// ----------------------------------------------------------------------------
// bdcm_pkg
// Types and constants shared by the direct context modeler and its channels.
// ----------------------------------------------------------------------------
`default_nettype none

package bdcm_pkg;

  // line store geometry
  localparam int unsigned MaxRowWidth = 4096;
  localparam int unsigned ColW        = $clog2(MaxRowWidth);

  // register and field widths
  localparam int unsigned ImgWidthW = 13;
  localparam int unsigned RowW      = 16;
  localparam int unsigned CtxW      = 10;
  localparam int unsigned CfgIdxW   = 4;
  localparam int unsigned CfgDataW  = 16;

  // width of column arithmetic: holds the clamped width and column + 2
  localparam int unsigned CmpW = (ImgWidthW > ColW + 1) ? ImgWidthW : ColW + 1;

  // upper rows of the previous context that survive a one column shift
  localparam logic [7:0] UpShiftMask = 8'h7B;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_IMAGE_WIDTH  = 4'd0,
    CFG_IMAGE_HEIGHT = 4'd1
  } cfg_reg_e;

  // one line store entry: row y-2 bit and row y-1 bit of one column
  typedef struct packed {
    logic r2;
    logic r1;
  } line_pair_t;

  typedef struct packed {
    logic [CtxW-1:0] context_index;
    logic            pixel_out;
    logic            row_end;
    logic            image_end;
  } res_t;

endpackage

`default_nettype wire

FILE: design/bdcm_ifs.sv
// ----------------------------------------------------------------------------
// bdcm channel interfaces
// Pixel input, context result and configuration write channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface bdcm_pix_if;
  logic valid;
  logic ready;
  logic pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

interface bdcm_res_if;
  import bdcm_pkg::*;
  logic            valid;
  logic            ready;
  logic [CtxW-1:0] context_index;
  logic            pixel_out;
  logic            row_end;
  logic            image_end;

  modport source (output valid, output context_index, output pixel_out,
                  output row_end, output image_end, input ready);
  modport sink   (input valid, input context_index, input pixel_out,
                  input row_end, input image_end, output ready);
endinterface

interface bdcm_cfg_if;
  import bdcm_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: design/bilevel_direct_context_modeler_core.sv
// ----------------------------------------------------------------------------
// bilevel_direct_context_modeler_core
// Forms the 10-bit direct coding context of each pixel of a bilevel symbol
// from two line stores and the current row, one pixel per cycle unless stalled.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                          | handshake
//  pix_i   | in  | pixel_in                                         | valid/ready
//  res_o   | out | context_index, pixel_out, row_end, image_end     | valid/ready
//  cfg_i   | in  | index, data (image_width, image_height)          | valid/ready
//
//  one pixel per cycle unless res_o stalls; a result is registered in out_q,
//  or in skid_q on a stall. the line store is one 4096 x 2 memory read one
//  column ahead into a three column window, so a single read port per cycle
//  is enough. reset clears counters and handshake state; line store contents stay
//  undefined until written. a stalled result waits in the output register,
//  one more pixel is taken into a skid register, then pix_i.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module bilevel_direct_context_modeler_core (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  bdcm_pix_if.sink    pix_i,
  bdcm_res_if.source  res_o,
  bdcm_cfg_if.sink    cfg_i
);
  import bdcm_pkg::*;

  // configuration
  logic [ImgWidthW-1:0] width_q;
  logic [RowW-1:0]      height_q;
  logic [CmpW-1:0]      eff_w;
  logic [RowW:0]        eff_h;

  // position and row history
  logic [ColW-1:0] col_q;
  logic [RowW-1:0] row_q;
  logic [1:0]      recent_q;
  logic [7:0]      upper_q;

  // line store and its read window
  line_pair_t      line_mem [MaxRowWidth];
  line_pair_t      rdata_q;
  line_pair_t      win0_q, win1_q, alt_q;
  logic            use_alt_q;
  line_pair_t      head_q [3];
  line_pair_t      head_d [3];
  line_pair_t      slot2;
  line_pair_t      wr_pair;
  logic [ColW-1:0] raddr;

  // per pixel logic
  logic            accept;
  logic            m1, m2, ok1, ok2;
  logic [CmpW-1:0] col_ext;
  logic [7:0]      ctx_up;
  logic [CtxW-1:0] ctx;
  logic            row_end_c, image_end_c;
  res_t            res_c;

  // output register and skid
  res_t out_q, skid_q;
  logic out_valid_q, skid_valid_q;
  logic out_fire;

  // ---------------------------------------------------------------- config
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= ImgWidthW'(1);
      height_q <= RowW'(1);
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_IMAGE_WIDTH:  width_q  <= cfg_i.data[ImgWidthW-1:0];
        CFG_IMAGE_HEIGHT: height_q <= cfg_i.data[RowW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_q == '0) begin
      eff_w = CmpW'(1);
    end else if (CmpW'(width_q) > CmpW'(MaxRowWidth)) begin
      eff_w = CmpW'(MaxRowWidth);
    end else begin
      eff_w = CmpW'(width_q);
    end
    eff_h = (height_q == '0) ? (RowW+1)'(1) : {1'b0, height_q};
  end

  // ---------------------------------------------------------------- context
  assign accept      = pix_i.valid && pix_i.ready;
  assign pix_i.ready = !skid_valid_q;

  assign col_ext = CmpW'(col_q);
  assign m1      = (row_q != '0);
  assign m2      = (row_q[RowW-1:1] != '0);
  assign ok1     = (col_ext + CmpW'(1)) < eff_w;
  assign ok2     = (col_ext + CmpW'(2)) < eff_w;
  assign slot2   = use_alt_q ? alt_q : rdata_q;

  always_comb begin
    if (col_q == '0) begin
      // left neighbours are outside the image
      ctx_up    = '0;
      ctx_up[1] = win0_q.r2 & m2;
      ctx_up[5] = win0_q.r1 & m1;
      ctx_up[6] = win1_q.r1 & m1 & ok1;
    end else begin
      ctx_up = (upper_q >> 1) & UpShiftMask;
    end
    ctx_up[2] = win1_q.r2 & m2 & ok1;
    ctx_up[7] = slot2.r1 & m1 & ok2;
  end

  assign ctx         = {recent_q[0], recent_q[1], ctx_up};
  assign row_end_c   = (col_ext + CmpW'(1)) >= eff_w;
  assign image_end_c = row_end_c && (({1'b0, row_q} + (RowW+1)'(1)) >= eff_h);

  assign wr_pair = '{r2: m1 & win0_q.r1, r1: pix_i.pixel_in};
  assign raddr   = col_q + ColW'(3);

  assign res_c = '{context_index: ctx, pixel_out: pix_i.pixel_in,
                   row_end: row_end_c, image_end: image_end_c};

  // copy of columns 0..2 as written this row, reloaded at each row start
  always_comb begin
    head_d = head_q;
    if (accept) begin
      case (col_q)
        ColW'(0): head_d[0] = wr_pair;
        ColW'(1): head_d[1] = wr_pair;
        ColW'(2): head_d[2] = wr_pair;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      recent_q  <= '0;
      upper_q   <= '0;
      use_alt_q <= 1'b1;
    end else if (accept) begin
      if (row_end_c) begin
        col_q     <= '0;
        row_q     <= image_end_c ? '0 : row_q + RowW'(1);
        recent_q  <= '0;
        upper_q   <= '0;
        use_alt_q <= 1'b1;
      end else begin
        col_q     <= col_q + ColW'(1);
        recent_q  <= {recent_q[0], pix_i.pixel_in};
        upper_q   <= ctx[7:0];
        use_alt_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    if (accept) begin
      if (row_end_c) begin
        win0_q <= head_d[0];
        win1_q <= head_d[1];
        alt_q  <= head_d[2];
      end else begin
        win0_q <= win1_q;
        win1_q <= slot2;
      end
    end
  end

  // line store: write the current column, prefetch three columns ahead
  always_ff @(posedge clk_i) begin
    if (accept) begin
      line_mem[col_q] <= wr_pair;
      rdata_q         <= line_mem[raddr];
    end
  end

  // ---------------------------------------------------------------- output
  assign out_fire = out_valid_q && res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || out_fire) begin
      out_valid_q  <= skid_valid_q || accept;
      skid_valid_q <= 1'b0;
    end else if (accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_fire) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (accept) begin
        out_q <= res_c;
      end
    end else if (accept) begin
      skid_q <= res_c;
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.context_index = out_q.context_index;
  assign res_o.pixel_out     = out_q.pixel_out;
  assign res_o.row_end       = out_q.row_end;
  assign res_o.image_end     = out_q.image_end;

  // ---------------------------------------------------------------- checks
  skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register holds an item while output register is empty");

  row_end_resets_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && row_end_c) |=> (col_q == '0 && use_alt_q))
    else $error("column did not return to zero after end of row");

  alt_only_at_row_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    use_alt_q |-> (col_q == '0))
    else $error("row start window selected away from column zero");

  image_end_has_row_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.image_end) |-> out_q.row_end)
    else $error("end of image flagged without end of row");

endmodule

`default_nettype wire
